// File: design/durd_pkg.sv
package durd_pkg;

   // Field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DAYS_W   = 22;
   localparam int SERIAL_W = 23;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 14;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam int DEFAULT_MAX_YEAR = 9999;

   // Reset values of the reference date
   localparam logic [YEAR_W-1:0]  REF_YEAR_RST  = 14'd2024;
   localparam logic [MONTH_W-1:0] REF_MONTH_RST = 4'd5;
   localparam logic [DAY_W-1:0]   REF_DAY_RST   = 5'd4;

   // Reciprocal of 100: floor(x * 5243 / 2^19) == floor(x / 100) for x < 2^14
   localparam int RECIP_W      = 13;
   localparam int MUL_W        = YEAR_W + RECIP_W;
   localparam int RECIP_SHIFT  = 19;
   localparam int QUOT_W       = MUL_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int CENTURY      = 100;
   localparam int DAYS_PER_YEAR = 365;
   localparam int LEAP_W       = 12;
   localparam int MOFF_W       = 9;
   localparam int REM_W        = 7;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_REF_YEAR  = 2'd0,
      CSR_REF_MONTH = 2'd1,
      CSR_REF_DAY   = 2'd2
   } csr_index_type;

   // Days before the first of the month in a common year
   function automatic logic [MOFF_W-1:0] month_start(input logic [MONTH_W-1:0] mo);
      logic [MOFF_W-1:0] r;
      begin
         case (mo)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// File: design/durd_serial.sv
module durd_serial #(
   parameter int MAX_YEAR = durd_pkg::DEFAULT_MAX_YEAR
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [durd_pkg::YEAR_W-1:0]     year,
   input  logic [durd_pkg::MONTH_W-1:0]    month,
   input  logic [durd_pkg::DAY_W-1:0]      day,
   output logic [durd_pkg::SERIAL_W-1:0]   serial
);
   import durd_pkg::*;

   // Stage 1 signals
   logic [YEAR_W-1:0]  yr_c;
   logic [MONTH_W-1:0] mo_c;
   logic [YEAR_W-1:0]  p_c;
   logic [YEAR_W-1:0]  yr_ff,  p_ff;
   logic [MONTH_W-1:0] mo1_ff;
   logic [DAY_W-1:0]   dy1_ff;
   logic [MUL_W-1:0]   pmul_in, pmul_ff, ymul_in, ymul_ff;

   // Stage 2 signals
   logic [QUOT_W-1:0]   pd100_c, yq_c;
   logic [YEAR_W-1:0]   yq100_c;
   logic [SERIAL_W-1:0] p365_in, p365_ff;
   logic [LEAP_W-1:0]   lday_in, lday_ff;
   logic [REM_W-1:0]    rem_in,  rem_ff;
   logic [1:0]          yqlo_ff, ylo_ff;
   logic [MONTH_W-1:0]  mo2_ff;
   logic [DAY_W-1:0]    dy2_ff;

   // Stage 3 signals
   logic                leap_c;
   logic [MOFF_W-1:0]   moff_c;
   logic [SERIAL_W-1:0] serial_in, serial_ff;

   // Clamp year and month, start the divisions by 100
   always_comb begin
      yr_c = (year == '0) ? YEAR_W'(1) : year;
      if (32'(yr_c) > 32'(MAX_YEAR)) begin
         yr_c = YEAR_W'(MAX_YEAR);
      end
      if (month == '0) begin
         mo_c = MONTH_JAN;
      end else if (month > MONTH_DEC) begin
         mo_c = MONTH_DEC;
      end else begin
         mo_c = month;
      end
      p_c     = yr_c - YEAR_W'(1);
      pmul_in = MUL_W'(p_c) * MUL_W'(RECIP_100);
      ymul_in = MUL_W'(yr_c) * MUL_W'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yr_ff   <= yr_c;
         p_ff    <= p_c;
         mo1_ff  <= mo_c;
         dy1_ff  <= day;
         pmul_ff <= pmul_in;
         ymul_ff <= ymul_in;
      end
   end

   // Days of whole years, leap days of earlier years, year remainder by 100
   always_comb begin
      pd100_c = pmul_ff[MUL_W-1:RECIP_SHIFT];
      yq_c    = ymul_ff[MUL_W-1:RECIP_SHIFT];
      yq100_c = YEAR_W'(yq_c) * YEAR_W'(CENTURY);
      rem_in  = REM_W'(yr_ff - yq100_c);
      p365_in = SERIAL_W'(p_ff) * SERIAL_W'(DAYS_PER_YEAR);
      lday_in = LEAP_W'(p_ff >> 2) - LEAP_W'(pd100_c) + LEAP_W'(pd100_c >> 2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p365_ff <= p365_in;
         lday_ff <= lday_in;
         rem_ff  <= rem_in;
         yqlo_ff <= yq_c[1:0];
         ylo_ff  <= yr_ff[1:0];
         mo2_ff  <= mo1_ff;
         dy2_ff  <= dy1_ff;
      end
   end

   // Leap test, month offset and final sum
   always_comb begin
      leap_c = ((ylo_ff == 2'd0) && (rem_ff != '0)) ||
               ((rem_ff == '0) && (yqlo_ff == 2'd0));
      moff_c = month_start(mo2_ff) +
               MOFF_W'((mo2_ff > MONTH_FEB) && leap_c);
      serial_in = p365_ff + SERIAL_W'(lday_ff) + SERIAL_W'(moff_c) + SERIAL_W'(dy2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         serial_ff <= serial_in;
      end
   end

   assign serial = serial_ff;

endmodule

// File: design/days_until_reference_date_top.sv
// Channel  | Direction | Beat contents
// req_     | in        | tdata: start_year[13:0], start_month[17:14], start_day[22:18], 0
// rsp_     | out       | tdata: days_elapsed[21:0], 0; tuser: status
// csr_     | in        | write: index 0 ref_year, 1 ref_month, 2 ref_day
//
// One date is taken per cycle unless a stalled result holds the pipeline.
// Two copies of the serial-day pipeline (three stages, the multiplies by the
// reciprocal of 100 and by 365 set the stage depth) run for start and reference.
// A fourth stage compares and subtracts, and is the output register.
// Reset is synchronous, clears the valid bits and reloads the reference date.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module days_until_reference_date_top #(
   parameter int MAX_YEAR = durd_pkg::DEFAULT_MAX_YEAR
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [durd_pkg::REQ_DATA_W-1:0]   req_tdata,  // start_year, start_month, start_day
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [durd_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // days_elapsed
   output logic                              rsp_tuser,  // status
   input  logic                              csr_we,
   input  logic [durd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [durd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import durd_pkg::*;

   logic                 en;
   logic [YEAR_W-1:0]    ref_year_ff;
   logic [MONTH_W-1:0]   ref_month_ff;
   logic [DAY_W-1:0]     ref_day_ff;
   logic [2:0]           vld_ff;
   logic                 out_vld_ff;
   logic [SERIAL_W-1:0]  st_serial, ref_serial, diff_c;
   logic                 after_c;
   logic [DAYS_W-1:0]    days_in, days_ff;
   logic                 status_in, status_ff;

   // Advance all stages unless the result register is held
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // Reference date registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_year_ff  <= REF_YEAR_RST;
         ref_month_ff <= REF_MONTH_RST;
         ref_day_ff   <= REF_DAY_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_REF_YEAR:  ref_year_ff  <= csr_wdata[YEAR_W-1:0];
            CSR_REF_MONTH: ref_month_ff <= csr_wdata[MONTH_W-1:0];
            CSR_REF_DAY:   ref_day_ff   <= csr_wdata[DAY_W-1:0];
            default: ;
         endcase
      end
   end

   durd_serial #(.MAX_YEAR(MAX_YEAR)) u_start (
      .clock  (clock),
      .en     (en),
      .year   (req_tdata[YEAR_W-1:0]),
      .month  (req_tdata[YEAR_W+MONTH_W-1:YEAR_W]),
      .day    (req_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W]),
      .serial (st_serial)
   );

   durd_serial #(.MAX_YEAR(MAX_YEAR)) u_ref (
      .clock  (clock),
      .en     (en),
      .year   (ref_year_ff),
      .month  (ref_month_ff),
      .day    (ref_day_ff),
      .serial (ref_serial)
   );

   // Carry valid bits alongside the serial pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[1:0], req_tvalid};
         out_vld_ff <= vld_ff[2];
      end
   end

   // Compare and subtract
   always_comb begin
      after_c   = st_serial > ref_serial;
      diff_c    = ref_serial - st_serial;
      status_in = after_c;
      days_in   = after_c ? '0 : diff_c[DAYS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         days_ff   <= days_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(days_ff);
   assign rsp_tuser  = status_ff;

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import durd_pkg::*;

   localparam int          MAX_YEAR    = DEFAULT_MAX_YEAR;
   localparam int          LATENCY     = 4;
   localparam int          HOLD_CYCLES = 300;
   localparam int          HOLD_AFTER  = 100;
   localparam int          PER_PHASE   = 205;
   localparam int unsigned CYCLE_LIMIT = 600000;

   // One day count owed by the block, in arrival order
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic              after_ref;
   } span_type;

   // Directed date; typed rows carry their span, the rest go to the predictor
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               typed;
      logic [DAYS_W-1:0]  days;
      logic               after_ref;
   } date_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // start_year, start_month, start_day, zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // days_elapsed, zero pad
   logic                  rsp_tuser;   // status
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Local copy of the reference date registers
   logic [YEAR_W-1:0]     ref_year_q  = REF_YEAR_RST;
   logic [MONTH_W-1:0]    ref_month_q = REF_MONTH_RST;
   logic [DAY_W-1:0]      ref_day_q   = REF_DAY_RST;

   span_type              pending_spans [$];
   date_row_type          date_rows [$];
   int                    mismatches     = 0;
   int                    accepted_dates = 0;
   int unsigned           cycles         = 0;
   bit                    no_idle        = 1'b0;

   days_until_reference_date_top #(.MAX_YEAR(MAX_YEAR)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Serial day number: whole years, leap days, earlier months, then the day
   function automatic int unsigned day_serial(input logic [YEAR_W-1:0] y,
                                              input logic [MONTH_W-1:0] m,
                                              input logic [DAY_W-1:0] d);
      int unsigned yy;
      int unsigned mm;
      int unsigned p;
      int unsigned n;
      bit          leap;
      yy = 32'(y);
      mm = 32'(m);
      if (yy < 1) yy = 1;
      if (yy > MAX_YEAR) yy = MAX_YEAR;
      if (mm < 1) mm = 1;
      if (mm > 12) mm = 12;
      p = yy - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400;
      for (int k = 1; k < mm; k++) begin
         if (k == 2) n += 28;
         else if (k == 4 || k == 6 || k == 9 || k == 11) n += 30;
         else n += 31;
      end
      leap = ((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0);
      if (mm > 2 && leap) n += 1;
      return n + 32'(d);
   endfunction

   function automatic span_type days_to_ref(input logic [YEAR_W-1:0] y,
                                            input logic [MONTH_W-1:0] m,
                                            input logic [DAY_W-1:0] d);
      int unsigned s;
      int unsigned r;
      span_type    sp;
      s = day_serial(y, m, d);
      r = day_serial(ref_year_q, ref_month_q, ref_day_q);
      if (s > r) begin
         sp.days      = '0;
         sp.after_ref = 1'b1;
      end else begin
         sp.days      = DAYS_W'(r - s);
         sp.after_ref = 1'b0;
      end
      return sp;
   endfunction

   // Mostly back to back, sometimes a short gap, now and then a long pause
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one date beat and book its span on acceptance
   task automatic offer_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d, input bit typed,
                             input span_type typed_span);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, d, m, y};
      do @(posedge clock); while (!req_tready);
      pending_spans.push_back(typed ? typed_span : days_to_ref(y, m, d));
      accepted_dates++;
   endtask

   task automatic random_dates(input int count);
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            // hover round the reference date so the order test flips
            0: begin
               y = ref_year_q + YEAR_W'($urandom_range(0, 2)) - YEAR_W'(1);
               m = ref_month_q;
               d = DAY_W'($urandom_range(0, 31));
            end
            1: begin
               y = ref_year_q;
               m = MONTH_W'($urandom_range(0, 15));
               d = DAY_W'($urandom_range(0, 31));
            end
            // raw field noise, out-of-range years and months included
            5: begin
               y = YEAR_W'($urandom);
               m = MONTH_W'($urandom);
               d = DAY_W'($urandom);
            end
            default: begin
               y = YEAR_W'($urandom_range(1, MAX_YEAR));
               m = MONTH_W'($urandom_range(1, 12));
               d = DAY_W'($urandom_range(1, 28));
            end
         endcase
         offer_date(y, m, d, 1'b0, '0);
      end
      no_idle = 1'b0;
   endtask

   // Drain the pipeline before touching the reference date
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic write_ref(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_REF_YEAR:  ref_year_q  = val[YEAR_W-1:0];
         CSR_REF_MONTH: ref_month_q = val[MONTH_W-1:0];
         CSR_REF_DAY:   ref_day_q   = val[DAY_W-1:0];
         default: ;
      endcase
      @(negedge clock) csr_we <= 1'b0;
   endtask

   task automatic set_ref(input logic [CSR_DATA_W-1:0] y, input logic [CSR_DATA_W-1:0] m,
                          input logic [CSR_DATA_W-1:0] d);
      write_ref(CSR_REF_YEAR, y);
      write_ref(CSR_REF_MONTH, m);
      write_ref(CSR_REF_DAY, d);
   endtask

   // Sink side: random back-pressure, and one long hold-off to fill the block
   initial begin
      int  gap;
      bit  held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && accepted_dates >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Compare each result beat with the oldest booked span
   always @(posedge clock) begin
      span_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_spans.size() == 0) begin
            $error("result beat with nothing outstanding: days_elapsed %0d status %0b",
                   rsp_tdata[DAYS_W-1:0], rsp_tuser);
            mismatches++;
         end else begin
            want = pending_spans.pop_front();
            if (rsp_tdata[DAYS_W-1:0] !== want.days) begin
               $error("days_elapsed: expected %0d, got %0d", want.days,
                      rsp_tdata[DAYS_W-1:0]);
               mismatches++;
            end
            if (rsp_tuser !== want.after_ref) begin
               $error("status: expected %0b, got %0b", want.after_ref, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;

      // Reference date is 2024-05-04 out of reset
      date_rows = '{
         '{14'd2024,  4'd5,  5'd4,  1'b1, 22'd0,   1'b0},
         '{14'd2024,  4'd5,  5'd5,  1'b1, 22'd0,   1'b1},
         '{14'd2024,  4'd5,  5'd3,  1'b1, 22'd1,   1'b0},
         '{14'd2023,  4'd5,  5'd4,  1'b1, 22'd366, 1'b0},
         '{14'd9999,  4'd12, 5'd31, 1'b1, 22'd0,   1'b1},
         '{14'd16383, 4'd15, 5'd31, 1'b1, 22'd0,   1'b1},
         '{14'd0,     4'd0,  5'd0,  1'b0, 22'd0,   1'b0},
         '{14'd1,     4'd1,  5'd1,  1'b0, 22'd0,   1'b0},
         '{14'd2024,  4'd2,  5'd29, 1'b0, 22'd0,   1'b0},
         '{14'd2024,  4'd3,  5'd1,  1'b0, 22'd0,   1'b0},
         '{14'd2023,  4'd2,  5'd28, 1'b0, 22'd0,   1'b0},
         '{14'd2000,  4'd3,  5'd1,  1'b0, 22'd0,   1'b0},
         '{14'd1900,  4'd3,  5'd1,  1'b0, 22'd0,   1'b0},
         '{14'd1600,  4'd12, 5'd31, 1'b0, 22'd0,   1'b0},
         '{14'd2100,  4'd3,  5'd1,  1'b0, 22'd0,   1'b0},
         '{14'd2024,  4'd0,  5'd4,  1'b0, 22'd0,   1'b0},
         '{14'd2024,  4'd13, 5'd1,  1'b0, 22'd0,   1'b0},
         '{14'd2024,  4'd2,  5'd31, 1'b0, 22'd0,   1'b0},
         '{14'd2024,  4'd5,  5'd0,  1'b0, 22'd0,   1'b0},
         '{14'd5461,  4'd10, 5'd21, 1'b0, 22'd0,   1'b0},
         '{14'd10922, 4'd5,  5'd10, 1'b0, 22'd0,   1'b0},
         '{14'd8192,  4'd8,  5'd16, 1'b0, 22'd0,   1'b0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (date_rows[i])
         offer_date(date_rows[i].year, date_rows[i].month, date_rows[i].day,
                    date_rows[i].typed, {date_rows[i].days, date_rows[i].after_ref});
      random_dates(PER_PHASE);

      // Walk the reference date through its extremes and a few ordinary dates
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: set_ref(14'd9999, 14'd12, 14'd31);
            1: set_ref(14'd1, 14'd1, 14'd1);
            2: set_ref(14'd0, 14'd0, 14'd0);
            3: set_ref(14'd16383, 14'd15, 14'd31);
            4: set_ref(14'd2000, 14'd2, 14'd29);
            default: set_ref(CSR_DATA_W'($urandom_range(1, MAX_YEAR)),
                             CSR_DATA_W'($urandom_range(1, 12)),
                             CSR_DATA_W'($urandom_range(1, 31)));
         endcase
         random_dates(PER_PHASE);
      end

      drain();
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
